[sv/assert_macros.svh]
// Assertion macros for the filter RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check cons in the same cycle whenever ante holds.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Check cons in the cycle after ante holds.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

[sv/dmef_pkg.sv]
// Shared types and constants for the dual median / average filter.
// No dependencies.
package dmef_pkg;

  localparam int DATA_W     = 16;
  localparam int WEIGHT_W   = 9;
  localparam int SHIFT      = 8;
  localparam int PROD_W     = WEIGHT_W + 1 + DATA_W;
  localparam int SUM_W      = PROD_W + 1;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << SHIFT);
  localparam logic [SUM_W-1:0]    ROUND_BIAS = SUM_W'((1 << SHIFT) - 1);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_RANK     = 6'b000010,
    ST_MUL_PREV = 6'b000100,
    ST_MUL_MED  = 6'b001000,
    ST_SCALE    = 6'b010000,
    ST_OUT      = 6'b100000
  } state_t;

endpackage

[sv/dual_median_ema_filter_unit.sv]
// Dual-channel sliding-window median filter followed by an exponential average.
// Depends on dmef_pkg and assert_macros.svh.

// Each request carries one steering and one current sample. Both are written into
// their WINDOW-entry circular windows (cleared to zero at reset), the median of each
// window is found, and it is blended into that channel's running average with
// weight blend_weight/256 (256, the reset value, passes the median straight
// through). The block works on one item at a time:
// one comparator bank ranks one window entry per cycle, and one 10x16 multiplier
// does both products of the blend, the two channels taking turns on both units.
// in_ready is low while an item is in flight; a finished result sits in the output
// register, so the next request can be taken before the result is collected.
`include "assert_macros.svh"

module dual_median_ema_filter_unit
  import dmef_pkg::*;
#(
  parameter int WINDOW = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [WEIGHT_W-1:0]        blend_weight,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [DATA_W-1:0]   steer_sample,
  input  logic signed [DATA_W-1:0]   current_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [DATA_W-1:0]   steer_filtered,
  output logic signed [DATA_W-1:0]   current_filtered
);

  localparam int IDX_W = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam logic [CNT_W-1:0] HALF     = CNT_W'(WINDOW / 2);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

  state_t state;

  logic signed [DATA_W-1:0] steer_win   [WINDOW];
  logic signed [DATA_W-1:0] current_win [WINDOW];
  logic signed [DATA_W-1:0] cur_win     [WINDOW];
  logic [IDX_W-1:0]         slot;
  logic [IDX_W-1:0]         rank_idx;
  logic                     ch;
  logic                     found;
  logic signed [DATA_W-1:0] med;
  logic signed [DATA_W-1:0] steer_avg;
  logic signed [DATA_W-1:0] current_avg;
  logic [WEIGHT_W-1:0]      weight;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  acc;

  logic signed [DATA_W-1:0] cand;
  logic [CNT_W-1:0]         cnt_less;
  logic [CNT_W-1:0]         cnt_le;
  logic                     hit;
  logic [WEIGHT_W-1:0]      op_w;
  logic signed [DATA_W-1:0] op_d;
  logic signed [DATA_W-1:0] prev_avg;
  logic signed [PROD_W-1:0] mult;
  logic signed [SUM_W-1:0]  acc_adj;
  logic signed [SUM_W-1:0]  scaled;
  logic signed [DATA_W-1:0] avg_new;
  logic                     in_acc;
  logic                     out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_load  = (state == ST_OUT) && (!out_valid || out_ready);

  // Rank bank: count entries below and not above the candidate.
  always_comb begin
    for (int j = 0; j < WINDOW; j++) begin
      cur_win[j] = ch ? current_win[j] : steer_win[j];
    end
    cand     = cur_win[rank_idx];
    cnt_less = '0;
    cnt_le   = '0;
    for (int j = 0; j < WINDOW; j++) begin
      if (cur_win[j] < cand) cnt_less = cnt_less + CNT_W'(1);
      if (cur_win[j] <= cand) cnt_le = cnt_le + CNT_W'(1);
    end
    hit = (cnt_less <= HALF) && (cnt_le > HALF);
  end

  // Shared multiplier: previous average first, then the median.
  always_comb begin
    prev_avg = ch ? current_avg : steer_avg;
    op_w     = (state == ST_MUL_PREV) ? WEIGHT_ONE - weight : weight;
    op_d     = (state == ST_MUL_PREV) ? prev_avg : med;
    mult     = $signed({1'b0, op_w}) * op_d;
    // Divide by 256 with truncation toward zero.
    acc_adj  = acc + (acc[SUM_W-1] ? ROUND_BIAS : '0);
    scaled   = acc_adj >>> SHIFT;
    avg_new  = scaled[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= WEIGHT_ONE;
    end else if (cfg_valid && cfg_ready) begin
      weight <= (blend_weight > WEIGHT_ONE) ? WEIGHT_ONE : blend_weight;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      slot        <= '0;
      rank_idx    <= '0;
      ch          <= 1'b0;
      found       <= 1'b0;
      steer_avg   <= '0;
      current_avg <= '0;
      out_valid   <= 1'b0;
      for (int j = 0; j < WINDOW; j++) begin
        steer_win[j]   <= '0;
        current_win[j] <= '0;
      end
    end else begin
      if (out_valid && out_ready && !out_load) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            steer_win[slot]   <= steer_sample;
            current_win[slot] <= current_sample;
            slot     <= (slot == LAST_IDX) ? '0 : slot + IDX_W'(1);
            ch       <= 1'b0;
            rank_idx <= '0;
            found    <= 1'b0;
            state    <= ST_RANK;
          end
        end
        ST_RANK: begin
          if (hit && !found) begin
            med   <= cand;
            found <= 1'b1;
          end
          if (rank_idx == LAST_IDX) begin
            state <= ST_MUL_PREV;
          end else begin
            rank_idx <= rank_idx + IDX_W'(1);
          end
        end
        ST_MUL_PREV: begin
          prod  <= mult;
          state <= ST_MUL_MED;
        end
        ST_MUL_MED: begin
          acc   <= SUM_W'(prod) + SUM_W'(mult);
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          if (ch) begin
            current_avg <= avg_new;
            state       <= ST_OUT;
          end else begin
            steer_avg <= avg_new;
            ch        <= 1'b1;
            rank_idx  <= '0;
            found     <= 1'b0;
            state     <= ST_RANK;
          end
        end
        ST_OUT: begin
          // Hold until the output register is free.
          if (out_load) begin
            steer_filtered   <= steer_avg;
            current_filtered <= current_avg;
            out_valid        <= 1'b1;
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_weight_range, clk, rst, 1'b1, weight <= WEIGHT_ONE, "weight above one")
  `ASSERT_IMPLIES(a_slot_range, clk, rst, 1'b1, slot <= LAST_IDX, "write slot out of range")
  `ASSERT_IMPLIES(a_median_found, clk, rst, (state == ST_RANK) && (rank_idx == LAST_IDX),
                  found || hit, "no median found in window")
  `ASSERT_NEXT(a_accept_start, clk, rst, in_acc,
               (state == ST_RANK) && (rank_idx == '0) && !ch && !found, "bad item start")
  `ASSERT_NEXT(a_out_load, clk, rst, out_load,
               out_valid && (steer_filtered == steer_avg), "output not loaded")

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// Testbench for dual_median_ema_filter_unit: directed table, then random phases per weight.
// Depends on dmef_pkg; checks each result against its table value or in-line prediction.
module tb;
  import dmef_pkg::*;

  localparam int WINDOW = 3;

  typedef logic signed [DATA_W-1:0] sample_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] steer;
    logic signed [DATA_W-1:0] current;
  } filtered_t;

  // weight < 0 keeps the current setting; exp_* only count where typed is set
  typedef struct packed {
    int                       weight;
    logic signed [DATA_W-1:0] steer;
    logic signed [DATA_W-1:0] current;
    bit                       typed;
    logic signed [DATA_W-1:0] exp_steer;
    logic signed [DATA_W-1:0] exp_current;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [WEIGHT_W-1:0] blend_weight = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  sample_t             steer_sample = '0;
  sample_t             current_sample = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  sample_t             steer_filtered;
  sample_t             current_filtered;

  // Predictor state
  sample_t steer_win [WINDOW] = '{default: '0};
  sample_t current_win [WINDOW] = '{default: '0};
  int      win_slot = 0;
  sample_t steer_avg = '0;
  sample_t current_avg = '0;
  int      model_weight = 256;

  filtered_t expected_filtered [$];
  int        errors = 0;
  int        accepted_count = 0;
  logic      burst_mode = 1'b0;
  logic      sink_hold = 1'b0;
  int        ready_run = 0;
  int        stall_run = 0;

  // Reset windows are zero, so the first medians are pulled toward zero.
  stim_row_t stim_table [18] = '{
    '{-1,  32767, -32768, 1'b1,      0,      0},
    '{-1,  32767, -32768, 1'b1,  32767, -32768},
    '{-1, -32768,  32767, 1'b1,  32767, -32768},
    '{-1, -32768,  32767, 1'b1, -32768,  32767},
    '{-1,      0,      0, 1'b1, -32768,  32767},
    '{-1,      1,     -1, 1'b1,      0,      0},
    '{-1,  21845, -21846, 1'b1,      1,     -1},
    '{-1, -21846,  21845, 1'b1,      1,     -1},
    '{ 0,    100,    200, 1'b1,      1,     -1},
    '{511,    -5,      5, 1'b1,     -5,    200},
    '{257,     7,     -7, 1'b1,      7,      5},
    '{128,  1000,  -1000, 1'b1,      7,     -1},
    '{-1,     -3,     -3, 1'b0,      0,      0},
    '{ 1,  32767, -32768, 1'b0,      0,      0},
    '{255, -32768, 32767, 1'b0,      0,      0},
    '{-1, -32768,  32767, 1'b0,      0,      0},
    '{ 3,  12345, -12345, 1'b0,      0,      0},
    '{256,     0,      0, 1'b0,      0,      0}
  };

  dual_median_ema_filter_unit #(
    .WINDOW(WINDOW)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .blend_weight(blend_weight),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .steer_sample(steer_sample),
    .current_sample(current_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .steer_filtered(steer_filtered),
    .current_filtered(current_filtered)
  );

  always #5 clk = ~clk;

  function automatic sample_t median_of(input sample_t win [WINDOW]);
    sample_t sorted [WINDOW];
    sample_t v;
    int      k;
    sorted = win;
    for (int i = 1; i < WINDOW; i++) begin
      v = sorted[i];
      k = i;
      while (k > 0 && sorted[k-1] > v) begin
        sorted[k] = sorted[k-1];
        k--;
      end
      sorted[k] = v;
    end
    return sorted[WINDOW/2];
  endfunction

  function automatic sample_t blend_avg(input sample_t prev, input sample_t med, input int w);
    int sum;
    // int division truncates toward zero
    sum = (int'(WEIGHT_ONE) - w) * int'(prev) + w * int'(med);
    return sample_t'(sum / int'(WEIGHT_ONE));
  endfunction

  function automatic filtered_t predict_filtered(input sample_t s, input sample_t c);
    filtered_t r;
    steer_win[win_slot] = s;
    current_win[win_slot] = c;
    win_slot = (win_slot == WINDOW - 1) ? 0 : win_slot + 1;
    steer_avg = blend_avg(steer_avg, median_of(steer_win), model_weight);
    current_avg = blend_avg(current_avg, median_of(current_win), model_weight);
    r.steer = steer_avg;
    r.current = current_avg;
    return r;
  endfunction

  // Mostly short gaps, a few long ones; none in burst phases.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode) return 0;
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return sample_t'(32767);
      1: return sample_t'(-32768);
      2: return sample_t'(int'($urandom_range(0, 20)) - 10);
      3: return '0;
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_sample(input sample_t s, input sample_t c, input bit has_exp,
                             input filtered_t exp_val);
    int        gap;
    filtered_t pred;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    steer_sample <= s;
    current_sample <= c;
    do @(posedge clk); while (!in_ready);
    pred = predict_filtered(s, c);
    expected_filtered.push_back(has_exp ? exp_val : pred);
    accepted_count++;
  endtask

  // Write only once every outstanding request has drained.
  task automatic write_weight(input int v);
    in_valid <= 1'b0;
    while (expected_filtered.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    blend_weight <= v[WEIGHT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_weight = (v > int'(WEIGHT_ONE)) ? int'(WEIGHT_ONE) : v;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      ready_run = 0;
      stall_run = 0;
    end else if (sink_hold) begin
      out_ready <= 1'b0;
    end else if (burst_mode || ready_run > 0) begin
      out_ready <= 1'b1;
      if (ready_run > 0) ready_run--;
    end else if (stall_run > 0) begin
      out_ready <= 1'b0;
      stall_run--;
    end else begin
      ready_run = $urandom_range(1, 12);
      stall_run = idle_len();
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    filtered_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_filtered.size() == 0) begin
        $display("%0t: unexpected result steer %0d current %0d", $time,
                 steer_filtered, current_filtered);
        errors++;
      end else begin
        want = expected_filtered.pop_front();
        if (steer_filtered !== want.steer) begin
          $display("%0t: steer_filtered expected %0d, got %0d", $time,
                   want.steer, steer_filtered);
          errors++;
        end
        if (current_filtered !== want.current) begin
          $display("%0t: current_filtered expected %0d, got %0d", $time,
                   want.current, current_filtered);
          errors++;
        end
      end
    end
  end

  // Hold the output off for a long stretch in the burst phase so the input backs up.
  initial begin
    wait (accepted_count >= 280);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (300) @(posedge clk);
    sink_hold <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int w;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      if (stim_table[i].weight >= 0) write_weight(stim_table[i].weight);
      send_sample(stim_table[i].steer, stim_table[i].current, stim_table[i].typed,
                  {stim_table[i].exp_steer, stim_table[i].exp_current});
    end

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: w = 256;
        1: w = 0;
        2: w = 511;
        3: w = 1;
        default: w = $urandom_range(0, 511);
      endcase
      write_weight(w);
      burst_mode <= (p == 4);
      repeat (62) send_sample(pick_sample(), pick_sample(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (expected_filtered.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
